// ----- hw/rtl/lsr_pkg.sv -----
// Shared widths and types for the linear setpoint ramp.
package lsr_pkg;

  localparam int VALUE_W    = 32;
  localparam int STEP_W     = 33;
  localparam int PERIOD_W   = 16;
  localparam int DIVIDEND_W = 33;
  localparam int DIVISOR_W  = 32;
  localparam int DIV_CNT_W  = 6;

  localparam logic [PERIOD_W-1:0] PERIOD_RESET = 16'd1000;

  typedef struct packed {
    logic                  start;
    logic [DIVIDEND_W-1:0] dividend;
    logic [DIVISOR_W-1:0]  divisor;
  } lsr_div_req_t;

endpackage

// ----- hw/rtl/lsr_div.sv -----
// Bit-serial restoring divider: one quotient bit per cycle, unsigned operands.
module lsr_div
  import lsr_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst,
  input  lsr_div_req_t          req,
  output logic                  done,
  output logic [DIVIDEND_W-1:0] quotient
);

  logic [DIVIDEND_W-1:0] quo;
  logic [DIVISOR_W-1:0]  rem;
  logic [DIVISOR_W-1:0]  divisor;
  logic [DIV_CNT_W-1:0]  cnt;
  logic                  running;

  logic [DIVISOR_W:0]    trial;
  logic [DIVISOR_W:0]    trial_sub;
  logic                  fits;

  assign trial     = {rem, quo[DIVIDEND_W-1]};
  assign trial_sub = trial - {1'b0, divisor};
  assign fits      = trial >= {1'b0, divisor};
  assign quotient  = quo;

  always_ff @(posedge clk) begin
    if (rst) begin
      running <= 1'b0;
      done    <= 1'b0;
      cnt     <= '0;
    end else begin
      done <= 1'b0;
      if (req.start) begin
        running <= 1'b1;
        cnt     <= DIV_CNT_W'(DIVIDEND_W);
      end else if (running) begin
        cnt <= cnt - 1'b1;
        if (cnt == DIV_CNT_W'(1)) begin
          running <= 1'b0;
          done    <= 1'b1;
        end
      end
    end
  end

  // datapath: shift the next dividend bit into the remainder, keep it if the divisor fits
  always_ff @(posedge clk) begin
    if (req.start) begin
      quo     <= req.dividend;
      rem     <= '0;
      divisor <= req.divisor;
    end else if (running) begin
      quo <= {quo[DIVIDEND_W-2:0], fits};
      rem <= fits ? trial_sub[DIVISOR_W-1:0] : trial[DIVISOR_W-1:0];
    end
  end

endmodule

// ----- hw/rtl/linear_setpoint_ramp_top.sv -----
// Linear ramp generator in signed Q16.16, one result per input tick.
// A stepping, finishing or idle tick passes ST_DECIDE, then ST_EMIT, which registers the
//   result once the output is free; a planning tick runs ramp_time / sample_period and
//   then |diff| / ticks through one shared bit-serial divider, the second only if ticks > 0.
// Throughput: one tick at a time; the next tick is taken once the result is registered.
// Reset (synchronous): idle, value 0, step 0, no ticks left, sample_period 1000.
module linear_setpoint_ramp_top
  import lsr_pkg::*;
(
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       cfg_valid,
  output logic                       cfg_ready,
  input  logic [PERIOD_W-1:0]        cfg_data,
  input  logic                       item_valid,
  output logic                       item_stall,
  input  logic signed [VALUE_W-1:0]  target,
  input  logic [VALUE_W-1:0]         ramp_time,
  output logic                       result_valid,
  input  logic                       result_stall,
  output logic signed [VALUE_W-1:0]  current_value,
  output logic                       done_res
);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_DECIDE,
    ST_DIV_TICKS,
    ST_DIV_STEP,
    ST_EMIT
  } state_t;

  state_t state;

  logic [PERIOD_W-1:0]       sample_period;
  logic                      busy;
  logic [VALUE_W-1:0]        ticks_left;
  logic signed [STEP_W-1:0]  step_size;
  logic signed [VALUE_W-1:0] value_reg;
  logic                      done_q;

  logic signed [VALUE_W-1:0] target_q;
  logic [VALUE_W-1:0]        ramp_q;
  logic signed [STEP_W-1:0]  diff_q;
  logic [VALUE_W-1:0]        ticks_q;

  lsr_div_req_t              div_req;
  logic                      div_done;
  logic [DIVIDEND_W-1:0]     div_quo;

  logic signed [STEP_W:0]    sum;
  logic signed [VALUE_W-1:0] sum_sat;
  logic [DIVIDEND_W-1:0]     diff_mag;
  logic                      out_free;

  assign item_stall = (state != ST_IDLE);
  assign cfg_ready  = (state == ST_IDLE);
  assign out_free   = !result_valid || !result_stall;

  assign sum = {{2{value_reg[VALUE_W-1]}}, value_reg} + {step_size[STEP_W-1], step_size};
  always_comb begin
    if (sum[STEP_W] != sum[VALUE_W-1] || sum[STEP_W-1] != sum[VALUE_W-1]) begin
      sum_sat = sum[STEP_W] ? {1'b1, {(VALUE_W-1){1'b0}}} : {1'b0, {(VALUE_W-1){1'b1}}};
    end else begin
      sum_sat = sum[VALUE_W-1:0];
    end
  end

  assign diff_mag = diff_q[STEP_W-1] ? DIVIDEND_W'(-diff_q) : DIVIDEND_W'(diff_q);

  lsr_div u_div (
    .clk      (clk),
    .rst      (rst),
    .req      (div_req),
    .done     (div_done),
    .quotient (div_quo)
  );

  always_ff @(posedge clk) begin
    if (cfg_valid && cfg_ready) begin
      sample_period <= cfg_data;
    end
    if (rst) begin
      sample_period <= PERIOD_RESET;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= ST_IDLE;
      busy          <= 1'b0;
      ticks_left    <= '0;
      step_size     <= '0;
      value_reg     <= '0;
      done_q        <= 1'b0;
      result_valid  <= 1'b0;
      div_req.start <= 1'b0;
    end else begin
      div_req.start <= 1'b0;
      if (result_valid && !result_stall) begin
        result_valid <= 1'b0;
      end
      unique case (state)
        ST_IDLE: begin
          if (item_valid) begin
            target_q <= target;
            ramp_q   <= ramp_time;
            state    <= ST_DECIDE;
          end
        end
        ST_DECIDE: begin
          done_q <= 1'b0;
          diff_q <= {target_q[VALUE_W-1], target_q} - {value_reg[VALUE_W-1], value_reg};
          if (busy && ticks_left <= VALUE_W'(1)) begin
            value_reg  <= target_q;
            busy       <= 1'b0;
            ticks_left <= '0;
            done_q     <= 1'b1;
            state      <= ST_EMIT;
          end else if (busy) begin
            value_reg  <= sum_sat;
            ticks_left <= ticks_left - 1'b1;
            state      <= ST_EMIT;
          end else if (value_reg == target_q) begin
            state <= ST_EMIT;
          end else if (sample_period == '0) begin
            // zero period gives zero ticks: jump to target
            value_reg <= target_q;
            step_size <= '0;
            done_q    <= 1'b1;
            state     <= ST_EMIT;
          end else begin
            div_req.start    <= 1'b1;
            div_req.dividend <= {1'b0, ramp_q};
            div_req.divisor  <= DIVISOR_W'(sample_period);
            state            <= ST_DIV_TICKS;
          end
        end
        ST_DIV_TICKS: begin
          if (div_done) begin
            ticks_q <= div_quo[VALUE_W-1:0];
            if (div_quo == '0) begin
              value_reg <= target_q;
              step_size <= '0;
              done_q    <= 1'b1;
              state     <= ST_EMIT;
            end else begin
              div_req.start    <= 1'b1;
              div_req.dividend <= diff_mag;
              div_req.divisor  <= div_quo[VALUE_W-1:0];
              state            <= ST_DIV_STEP;
            end
          end
        end
        ST_DIV_STEP: begin
          if (div_done) begin
            // truncate toward zero: divide magnitudes, restore sign
            step_size  <= diff_q[STEP_W-1] ? STEP_W'(-div_quo) : STEP_W'(div_quo);
            ticks_left <= ticks_q;
            busy       <= 1'b1;
            state      <= ST_EMIT;
          end
        end
        ST_EMIT: begin
          if (out_free) begin
            current_value <= value_reg;
            done_res      <= done_q;
            result_valid  <= 1'b1;
            state         <= ST_IDLE;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  a_accept_to_decide: assert property (@(posedge clk) disable iff (rst)
    item_valid && !item_stall |=> state == ST_DECIDE)
    else $error("accepted transaction did not enter decision");

  a_busy_has_ticks: assert property (@(posedge clk) disable iff (rst)
    busy |-> ticks_left != '0)
    else $error("ramp running with no ticks left");

  a_div_done_state: assert property (@(posedge clk) disable iff (rst)
    div_done |-> state == ST_DIV_TICKS || state == ST_DIV_STEP)
    else $error("divider finished outside a division state");

  a_emit_loads: assert property (@(posedge clk) disable iff (rst)
    state == ST_EMIT && out_free |=> result_valid && state == ST_IDLE)
    else $error("result not registered on emit");

endmodule

// ----- tb/tb_top.sv -----
// Self-checking testbench for the linear setpoint ramp generator.
`timescale 1ns / 1ps

// Tracks the ramp state and the stream of expected tick results.
class ramp_checker;
  logic [lsr_pkg::PERIOD_W-1:0]       period;
  bit                                 busy;
  logic [31:0]                        ticks_left;
  longint                             step;
  logic signed [lsr_pkg::VALUE_W-1:0] value;
  logic signed [lsr_pkg::VALUE_W-1:0] value_q[$];
  bit                                 done_q[$];
  int                                 mismatches;

  function new();
    period     = lsr_pkg::PERIOD_RESET;
    busy       = 1'b0;
    ticks_left = '0;
    step       = 0;
    value      = '0;
    mismatches = 0;
  endfunction

  function int pending();
    return value_q.size();
  endfunction

  // Advance the ramp by one tick and queue the value and done flag it produces.
  function void advance_ramp(input logic signed [31:0] tgt, input logic [31:0] rt);
    logic [31:0] ticks;
    longint      sum;
    longint      diff;
    bit          done;
    done = 1'b0;
    if (busy && ticks_left <= 32'd1) begin
      // last tick lands exactly on the target carried by this tick
      value      = tgt;
      busy       = 1'b0;
      ticks_left = '0;
      done       = 1'b1;
    end else if (busy) begin
      sum = longint'(value) + step;
      if (sum > 64'sd2147483647) value = 32'sh7FFF_FFFF;
      else if (sum < -64'sd2147483648) value = 32'sh8000_0000;
      else value = sum[31:0];
      ticks_left = ticks_left - 32'd1;
    end else if (value != tgt) begin
      ticks = (period == '0) ? 32'd0 : rt / {16'd0, period};
      if (ticks == 32'd0) begin
        value = tgt;
        step  = 0;
        done  = 1'b1;
      end else begin
        diff       = longint'(tgt) - longint'(value);
        step       = diff / longint'(ticks);
        ticks_left = ticks;
        busy       = 1'b1;
      end
    end
    value_q.push_back(value);
    done_q.push_back(done);
  endfunction

  function void report_mismatch(input string what, input longint exp_v, input longint got_v);
    mismatches++;
    if (mismatches <= 10)
      $display("MISMATCH %s: expected %0d, got %0d", what, exp_v, got_v);
  endfunction

  function void check_output(input logic signed [31:0] val, input logic dn);
    logic signed [31:0] exp_value;
    bit                 exp_done;
    if (value_q.size() == 0) begin
      report_mismatch("unexpected tick result, current_value", 0, val);
      return;
    end
    exp_value = value_q.pop_front();
    exp_done  = done_q.pop_front();
    if (val !== exp_value) report_mismatch("current_value", exp_value, val);
    if (dn !== exp_done) report_mismatch("done_res", exp_done, dn);
  endfunction
endclass

module tb_top;
  import lsr_pkg::*;

  localparam logic signed [VALUE_W-1:0] V_MAX = 32'sh7FFF_FFFF;
  localparam logic signed [VALUE_W-1:0] V_MIN = 32'sh8000_0000;
  localparam int HOLD_CYCLES = 400;

  logic                       clk;
  logic                       rst;
  logic                       cfg_valid;
  logic                       cfg_ready;
  logic [PERIOD_W-1:0]        cfg_data;
  logic                       item_valid;
  logic                       item_stall;
  logic signed [VALUE_W-1:0]  target;
  logic [VALUE_W-1:0]         ramp_time;
  logic                       result_valid;
  logic                       result_stall;
  logic signed [VALUE_W-1:0]  current_value;
  logic                       done_res;

  ramp_checker chk;
  bit          quiet;
  bit          hold_off_req;
  int          tx_odds;

  logic signed [VALUE_W-1:0]  goal;
  logic signed [VALUE_W-1:0]  tgt;
  logic [VALUE_W-1:0]         rt;
  int                         k;

  linear_setpoint_ramp_top u_top (
    .clk           (clk),
    .rst           (rst),
    .cfg_valid     (cfg_valid),
    .cfg_ready     (cfg_ready),
    .cfg_data      (cfg_data),
    .item_valid    (item_valid),
    .item_stall    (item_stall),
    .target        (target),
    .ramp_time     (ramp_time),
    .result_valid  (result_valid),
    .result_stall  (result_stall),
    .current_value (current_value),
    .done_res      (done_res)
  );

  initial clk = 1'b0;
  always #5 clk = ~clk;

  // Offer one tick transaction; called and returns at a falling edge.
  task automatic send_tick(input logic signed [31:0] t, input logic [31:0] r);
    if (!quiet && tx_odds > $urandom_range(0, 7)) begin
      item_valid <= 1'b0;
      repeat ($urandom_range(1, 7)) @(negedge clk);
    end
    item_valid <= 1'b1;
    target     <= t;
    ramp_time  <= r;
    do @(posedge clk); while (item_stall);
    chk.advance_ramp(t, r);
    @(negedge clk);
  endtask

  // Drain all results, then write sample_period.
  task automatic write_period(input logic [PERIOD_W-1:0] p);
    item_valid <= 1'b0;
    while (chk.pending() != 0) @(negedge clk);
    repeat (4) @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_data  <= p;
    do @(posedge clk); while (!cfg_ready);
    chk.period = p;
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  always @(posedge clk) begin
    if (!rst && result_valid && !result_stall)
      chk.check_output(current_value, done_res);
  end

  // Result side: random stall bursts, calm stretches, and one long hold-off.
  initial begin : result_side
    int seg_left;
    int rx_odds;
    seg_left     = 0;
    rx_odds      = 0;
    result_stall = 1'b0;
    forever begin
      @(negedge clk);
      if (seg_left == 0) begin
        seg_left = $urandom_range(20, 80);
        rx_odds  = $urandom_range(0, 3);
      end
      seg_left--;
      if (hold_off_req) begin
        result_stall <= 1'b1;
        repeat (HOLD_CYCLES) @(negedge clk);
        hold_off_req = 1'b0;
        result_stall <= 1'b0;
      end else if (!quiet && rx_odds > $urandom_range(0, 7)) begin
        result_stall <= 1'b1;
        repeat ($urandom_range(1, 7)) @(negedge clk);
        result_stall <= 1'b0;
      end else begin
        result_stall <= 1'b0;
      end
    end
  end

  initial begin
    #5_000_000;
    $display("simulation failed");
    $finish;
  end

  initial begin
    rst          = 1'b1;
    cfg_valid    = 1'b0;
    cfg_data     = '0;
    item_valid   = 1'b0;
    target       = '0;
    ramp_time    = '0;
    quiet        = 1'b0;
    hold_off_req = 1'b0;
    tx_odds      = 0;
    goal         = '0;
    chk          = new();
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // Directed: equal target, jumps, full-range ramp, target change on the last tick.
    send_tick(32'sd0, 32'd0);
    send_tick(V_MIN, 32'd0);
    send_tick(V_MAX, 32'd3000);
    send_tick(V_MAX, 32'hFFFF_FFFF);
    send_tick(V_MAX, 32'd0);
    send_tick(32'sh1234_5678, 32'd0);
    send_tick(V_MIN, 32'd1999);
    send_tick(V_MIN, 32'd5);
    send_tick(V_MAX, 32'd999);
    // negative step, truncated toward zero
    send_tick(-32'sd1, 32'd5000);
    repeat (4) send_tick(-32'sd1, $urandom);
    write_period(16'hFFFF);
    send_tick(32'sh7FFF_0000, 32'd65535 * 2 + 32'd65534);
    repeat (2) send_tick(32'sh7FFF_0000, $urandom);
    // zero period: jump at once
    write_period(16'd0);
    send_tick(32'sd5, 32'hFFFF_FFFF);
    write_period(16'd1);
    send_tick(-32'sd5, 32'd7);
    repeat (7) send_tick(-32'sd5, 32'd0);

    // Random: mostly complete ramps toward a held goal, some noise on the target.
    for (int n = 0; n < 820; n++) begin
      if (n % 150 == 0) begin
        case ($urandom_range(0, 5))
          0:       write_period(16'd1);
          1:       write_period(16'hFFFF);
          2:       write_period(16'd0);
          3:       write_period(PERIOD_RESET);
          default: write_period(16'($urandom_range(1, 65535)));
        endcase
      end
      if (n % 32 == 0) tx_odds = $urandom_range(0, 3);
      if (n == 300) hold_off_req = 1'b1;
      quiet = (n >= 720);
      if ((!chk.busy && chk.value == goal && $urandom_range(0, 3) != 0) ||
          $urandom_range(0, 15) == 0) begin
        case ($urandom_range(0, 5))
          0:       goal = V_MIN;
          1:       goal = V_MAX;
          2:       goal = '0;
          3:       goal = chk.value + $urandom_range(0, 2000) - 1000;
          default: goal = $urandom;
        endcase
      end
      tgt = ($urandom_range(0, 9) == 0) ? $urandom : goal;
      if (chk.busy || tgt == chk.value || chk.period == '0) begin
        rt = $urandom;
      end else begin
        k  = ($urandom_range(0, 15) == 0) ? $urandom_range(0, 40) : $urandom_range(0, 12);
        rt = chk.period * k + $urandom_range(0, chk.period - 1);
      end
      send_tick(tgt, rt);
    end

    // Finish the open ramp, then plan a very long one and step into it.
    write_period(16'd1);
    while (chk.busy) send_tick(goal, $urandom);
    tgt = chk.value ^ V_MIN;
    send_tick(tgt, 32'hFFFF_FF00 | $urandom_range(0, 255));
    repeat (10) send_tick(tgt, $urandom);
    item_valid <= 1'b0;

    while (chk.pending() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
    if (chk.mismatches == 0 && chk.pending() == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule
